/* hw/rtl/gbf_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the bilinear form core.
`timescale 1ns / 1ps

package gbf_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_DIMENSION_DEF = 16;
	localparam int MAX_VECTORS_DEF   = 256;

	// Field widths of the streaming payload.
	localparam int OP_W      = 2;
	localparam int INDEX_W   = 8;
	localparam int GRAM_W    = 32;
	localparam int COMP_W    = 8;
	localparam int FORM_W    = 55;
	localparam int IN_DATA_W = 56;
	localparam int OUT_DATA_W = 56;

	// Width of the a[i]*b[j]*G[i][j] product before accumulation.
	localparam int PROD_W = 48;

	// Configuration port widths and register indexes.
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_DIMENSION    = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_COUNT = 8'd1;

	// Register reset values.
	localparam logic [4:0] DIMENSION_RESET    = 5'd16;
	localparam logic [8:0] VECTOR_COUNT_RESET = 9'd256;

	// Saturation bound of the form value, 2^53.
	localparam logic signed [63:0] FORM_LIMIT = 64'sd9007199254740992;

	// Operation codes carried in the input tuser.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD_GRAM   = 2'd0,
		OP_LOAD_VECTOR = 2'd1,
		OP_QUERY       = 2'd2
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_gram;   // write one Gram entry from the input beat
		logic wr_vec;    // write one vector component from the input beat
		logic start;     // latch query indices and clear the accumulator
		logic issue;     // issue one multiply-accumulate term at row/column
		logic last;      // the issued term is the final one of the query
		logic load_out;  // move the finished result into the output register
		logic err;       // the result being loaded is an index error
	} gbf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic acc_done;  // final term enters the accumulator this cycle
		logic out_free;  // output register can take a result this cycle
	} gbf_status_t;

endpackage

/* hw/rtl/gbf_ctrl.sv */
// Controller: configuration registers, input decode and the query sequencer state machine.
`timescale 1ns / 1ps

module gbf_ctrl #(
	parameter int MAX_DIMENSION = gbf_pkg::MAX_DIMENSION_DEF,
	parameter int MAX_VECTORS   = gbf_pkg::MAX_VECTORS_DEF,
	localparam int IDX_W = $clog2(MAX_DIMENSION),
	localparam int N_W   = $clog2(MAX_DIMENSION + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gbf_pkg::OP_W-1:0]            op,
	input  logic [gbf_pkg::INDEX_W-1:0]         first_index,
	input  logic [gbf_pkg::INDEX_W-1:0]         second_index,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gbf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gbf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  gbf_pkg::gbf_status_t                status,
	output gbf_pkg::gbf_cmd_t                   cmd,
	output logic [IDX_W-1:0]                    row_idx,
	output logic [IDX_W-1:0]                    col_idx
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic              live_q;
	logic [4:0]        dimension_q;
	logic [8:0]        vector_count_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic              err_q;

	logic              in_beat;
	logic [N_W-1:0]    n_eff;
	logic [N_W-1:0]    n_last;
	logic [31:0]       cnt_eff;
	logic              query_err;
	logic              row_last;
	logic              col_last;
	logic              gram_in_range;
	logic              vec_in_range;

	// Both channels stay closed while reset is asserted.
	assign cfg_ready = live_q;
	assign s_tready  = live_q && (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign row_idx   = i_q;
	assign col_idx   = j_q;

	// Effective dimension and vector count, capped at the built sizes.
	always_comb begin
		if (32'(dimension_q) > MAX_DIMENSION) begin
			n_eff = N_W'(MAX_DIMENSION);
		end else begin
			n_eff = N_W'(dimension_q);
		end
		if (32'(vector_count_q) > MAX_VECTORS) begin
			cnt_eff = 32'(MAX_VECTORS);
		end else begin
			cnt_eff = 32'(vector_count_q);
		end
	end

	assign n_last    = n_eff - N_W'(1);
	assign query_err = (32'(first_index) >= cnt_eff) || (32'(second_index) >= cnt_eff);
	assign row_last  = (32'(i_q) == 32'(n_last));
	assign col_last  = (32'(j_q) == 32'(n_last));

	// Loads outside the built store sizes are dropped.
	assign gram_in_range = (32'(first_index) < MAX_DIMENSION) &&
		(32'(second_index) < MAX_DIMENSION);
	assign vec_in_range  = (32'(first_index) < MAX_VECTORS) &&
		(32'(second_index) < MAX_DIMENSION);

	// Command decode.
	always_comb begin
		cmd = '0;
		cmd.err = err_q;
		if (in_beat) begin
			case (gbf_pkg::op_t'(op))
				gbf_pkg::OP_LOAD_GRAM: begin
					cmd.wr_gram = gram_in_range;
				end
				gbf_pkg::OP_LOAD_VECTOR: begin
					cmd.wr_vec = vec_in_range;
				end
				gbf_pkg::OP_QUERY: begin
					cmd.start = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_RUN) begin
			cmd.issue = 1'b1;
			cmd.last  = row_last && col_last;
		end
		if (state_q == ST_DONE) begin
			cmd.load_out = status.out_free;
		end
	end

	// State, counters and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			live_q         <= 1'b0;
			dimension_q    <= gbf_pkg::DIMENSION_RESET;
			vector_count_q <= gbf_pkg::VECTOR_COUNT_RESET;
			i_q            <= '0;
			j_q            <= '0;
			err_q          <= 1'b0;
		end else begin
			live_q <= 1'b1;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == gbf_pkg::REG_DIMENSION) begin
					dimension_q <= cfg_data[4:0];
				end else if (cfg_index == gbf_pkg::REG_VECTOR_COUNT) begin
					vector_count_q <= cfg_data[8:0];
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						i_q   <= '0;
						j_q   <= '0;
						err_q <= query_err;
						if (query_err || (n_eff == '0)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (col_last) begin
						j_q <= '0;
						i_q <= i_q + IDX_W'(1);
						if (row_last) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (status.acc_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/gbf_datapath.sv */
// Datapath: Gram and vector memories, multiply-accumulate pipeline and output register.
`timescale 1ns / 1ps

module gbf_datapath #(
	parameter int MAX_DIMENSION = gbf_pkg::MAX_DIMENSION_DEF,
	parameter int MAX_VECTORS   = gbf_pkg::MAX_VECTORS_DEF,
	localparam int IDX_W   = $clog2(MAX_DIMENSION),
	localparam int GDEPTH  = MAX_DIMENSION * MAX_DIMENSION,
	localparam int VDEPTH  = MAX_VECTORS * MAX_DIMENSION,
	localparam int GADDR_W = $clog2(GDEPTH),
	localparam int VADDR_W = $clog2(VDEPTH),
	localparam int ACC_W   = gbf_pkg::PROD_W + 2 * $clog2(MAX_DIMENSION)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gbf_pkg::gbf_cmd_t                   cmd,
	output gbf_pkg::gbf_status_t                status,
	input  logic [gbf_pkg::INDEX_W-1:0]         first_index,
	input  logic [gbf_pkg::INDEX_W-1:0]         second_index,
	input  logic signed [gbf_pkg::GRAM_W-1:0]   gram_value,
	input  logic signed [gbf_pkg::COMP_W-1:0]   component,
	input  logic [IDX_W-1:0]                    row_idx,
	input  logic [IDX_W-1:0]                    col_idx,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gbf_pkg::FORM_W-1:0]          form_value,
	output logic                                index_error
);

	logic signed [gbf_pkg::GRAM_W-1:0] gram_mem [GDEPTH];
	logic signed [gbf_pkg::COMP_W-1:0] vec_mem  [VDEPTH];

	logic [gbf_pkg::INDEX_W-1:0]       a_idx_q;
	logic [gbf_pkg::INDEX_W-1:0]       b_idx_q;

	logic [GADDR_W-1:0]                gram_wr_addr;
	logic [VADDR_W-1:0]                vec_wr_addr;
	logic [GADDR_W-1:0]                gram_rd_addr;
	logic [VADDR_W-1:0]                a_rd_addr;
	logic [VADDR_W-1:0]                b_rd_addr;

	logic signed [gbf_pkg::COMP_W-1:0]   a_s1;
	logic signed [gbf_pkg::COMP_W-1:0]   b_s1;
	logic signed [gbf_pkg::GRAM_W-1:0]   g_s1;
	logic signed [2*gbf_pkg::COMP_W-1:0] ab_s2;
	logic signed [gbf_pkg::GRAM_W-1:0]   g_s2;
	logic signed [gbf_pkg::PROD_W-1:0]   prod_s3;
	logic                                v_s1, v_s2, v_s3;
	logic                                last_s1, last_s2, last_s3;

	logic signed [ACC_W-1:0]           acc_q;
	logic signed [63:0]                acc_wide;
	logic signed [63:0]                acc_sat;

	logic                              out_valid_q;
	logic [gbf_pkg::FORM_W-1:0]        form_q;
	logic                              err_q;

	// Store addresses: entry row*MAX_DIMENSION+col and vec*MAX_DIMENSION+comp.
	assign gram_wr_addr = GADDR_W'(32'(first_index) * MAX_DIMENSION + 32'(second_index));
	assign vec_wr_addr  = VADDR_W'(32'(first_index) * MAX_DIMENSION + 32'(second_index));
	assign gram_rd_addr = GADDR_W'(32'(row_idx) * MAX_DIMENSION + 32'(col_idx));
	assign a_rd_addr    = VADDR_W'(32'(a_idx_q) * MAX_DIMENSION + 32'(row_idx));
	assign b_rd_addr    = VADDR_W'(32'(b_idx_q) * MAX_DIMENSION + 32'(col_idx));

	// Gram memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_gram) begin
			gram_mem[gram_wr_addr] <= gram_value;
		end
		g_s1 <= gram_mem[gram_rd_addr];
	end

	// Vector memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.wr_vec) begin
			vec_mem[vec_wr_addr] <= component;
		end
		a_s1 <= vec_mem[a_rd_addr];
		b_s1 <= vec_mem[b_rd_addr];
	end

	// Query operands and the product pipeline.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_idx_q <= first_index;
			b_idx_q <= second_index;
		end
		last_s1 <= cmd.last;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		ab_s2   <= a_s1 * b_s1;
		g_s2    <= g_s1;
		prod_s3 <= ab_s2 * g_s2;
	end

	// Accumulator, cleared when a query starts.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
	end

	// Valid bits of the product pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Saturate the sum to plus or minus 2^53.
	always_comb begin
		acc_wide = 64'(acc_q);
		if (acc_wide > gbf_pkg::FORM_LIMIT) begin
			acc_sat = gbf_pkg::FORM_LIMIT;
		end else if (acc_wide < -gbf_pkg::FORM_LIMIT) begin
			acc_sat = -gbf_pkg::FORM_LIMIT;
		end else begin
			acc_sat = acc_wide;
		end
	end

	// Output register holding one result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			err_q <= cmd.err;
			if (cmd.err) begin
				form_q <= '0;
			end else begin
				form_q <= acc_sat[gbf_pkg::FORM_W-1:0];
			end
		end
	end

	assign status.acc_done = v_s3 && last_s3;
	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign form_value      = form_q;
	assign index_error     = err_q;

endmodule

/* hw/rtl/gram_bilinear_form_matrix_core.sv */
// Top level of the bilinear form core over a stored Gram matrix and short vectors.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+---------------------------------------------
//   s_      | in        | s_tvalid / s_tready | tuser: op; tdata: indices, Gram word, component
//   m_      | out       | m_tvalid / m_tready | tuser: index_error; tdata: form_value
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A query issues one multiply-accumulate per cycle through the single Gram read port,
// n*n terms for dimension n, through three pipeline stages and then the result state;
// an index error or dimension zero goes straight to the result state.
// Reset clears control state and holds both readies low; stores are undefined until written.
// A finished result waits in the output register while loads keep flowing; a second
// query holds in its result state until that register is free.
`timescale 1ns / 1ps

module gram_bilinear_form_matrix_core #(
	parameter int MAX_DIMENSION = gbf_pkg::MAX_DIMENSION_DEF,
	parameter int MAX_VECTORS   = gbf_pkg::MAX_VECTORS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] first_index, [15:8] second_index, [47:16] gram_value, [55:48] component
	input  logic [gbf_pkg::IN_DATA_W-1:0]       s_tdata,
	// [1:0] op
	input  logic [gbf_pkg::OP_W-1:0]            s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [54:0] form_value, [55] zero fill
	output logic [gbf_pkg::OUT_DATA_W-1:0]      m_tdata,
	// [0] index_error
	output logic                                m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gbf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gbf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(MAX_DIMENSION);

	gbf_pkg::gbf_cmd_t                 cmd;
	gbf_pkg::gbf_status_t              status;
	logic [IDX_W-1:0]                  row_idx;
	logic [IDX_W-1:0]                  col_idx;
	logic [gbf_pkg::FORM_W-1:0]        form_value;

	// Sequencer and configuration registers.
	gbf_ctrl #(
		.MAX_DIMENSION (MAX_DIMENSION),
		.MAX_VECTORS   (MAX_VECTORS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.op           (s_tuser),
		.first_index  (s_tdata[7:0]),
		.second_index (s_tdata[15:8]),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status       (status),
		.cmd          (cmd),
		.row_idx      (row_idx),
		.col_idx      (col_idx)
	);

	// Stores, multiply-accumulate pipeline and result register.
	gbf_datapath #(
		.MAX_DIMENSION (MAX_DIMENSION),
		.MAX_VECTORS   (MAX_VECTORS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.first_index  (s_tdata[7:0]),
		.second_index (s_tdata[15:8]),
		.gram_value   (s_tdata[47:16]),
		.component    (s_tdata[55:48]),
		.row_idx      (row_idx),
		.col_idx      (col_idx),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.form_value   (form_value),
		.index_error  (m_tuser)
	);

	// Result beat packing with zero fill to whole bytes.
	assign m_tdata = {1'b0, form_value};

endmodule

/* test/gbf_form_checker.sv */
// Scoreboard for the bilinear form core: mirrors loads and register writes, scores result beats.
`timescale 1ns / 1ps

module gbf_form_checker #(
	parameter int MAX_DIMENSION = gbf_pkg::MAX_DIMENSION_DEF,
	parameter int MAX_VECTORS   = gbf_pkg::MAX_VECTORS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	// [7:0] first_index, [15:8] second_index, [47:16] gram_value, [55:48] component
	input  logic [gbf_pkg::IN_DATA_W-1:0]      s_tdata,
	// [1:0] op
	input  logic [gbf_pkg::OP_W-1:0]           s_tuser,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	// [54:0] form_value, [55] zero fill
	input  logic [gbf_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] index_error
	input  logic                               m_tuser,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [gbf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gbf_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                 outstanding,
	output int                                 fail_count
);
	import gbf_pkg::*;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [FORM_W-1:0] form_value;
		logic              index_error;
	} form_result_t;

	// Mirror of the block's stores and registers.
	logic signed [GRAM_W-1:0] gram_mem [MAX_DIMENSION][MAX_DIMENSION];
	logic signed [COMP_W-1:0] vec_mem [MAX_VECTORS][MAX_DIMENSION];
	logic [4:0]               dim_reg;
	logic [8:0]               count_reg;
	form_result_t             pending_forms [$];
	int                       mismatches;

	// Exact a^T G b over the active dimension, saturated to plus or minus 2^53, or an index error.
	function automatic form_result_t predict_form(logic [INDEX_W-1:0] a_idx,
			logic [INDEX_W-1:0] b_idx);
		int unsigned  n;
		int unsigned  cnt;
		longint       acc;
		form_result_t res;
		n = (dim_reg > MAX_DIMENSION) ? MAX_DIMENSION : dim_reg;
		cnt = (count_reg > MAX_VECTORS) ? MAX_VECTORS : count_reg;
		res = '0;
		if (a_idx >= cnt || b_idx >= cnt) begin
			res.index_error = 1'b1;
			return res;
		end
		acc = 0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				acc += longint'(vec_mem[a_idx][i]) * longint'(vec_mem[b_idx][j]) *
					longint'(gram_mem[i][j]);
			end
		end
		if (acc > FORM_LIMIT)
			acc = FORM_LIMIT;
		else if (acc < -FORM_LIMIT)
			acc = -FORM_LIMIT;
		res.form_value = acc[FORM_W-1:0];
		return res;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: mismatch on %s: expected %h, got %h", $time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		form_result_t       want;
		form_result_t       got;
		op_t                op;
		logic [INDEX_W-1:0] first_idx;
		logic [INDEX_W-1:0] second_idx;
		if (!arst_n) begin
			dim_reg = DIMENSION_RESET;
			count_reg = VECTOR_COUNT_RESET;
			pending_forms.delete();
			mismatches = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			// Register writes; unknown indexes are dropped.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DIMENSION)
					dim_reg = cfg_data[4:0];
				else if (cfg_index == REG_VECTOR_COUNT)
					count_reg = cfg_data[8:0];
			end

			// Score each result beat against the oldest pending query.
			if (m_tvalid && m_tready) begin
				got.form_value = m_tdata[FORM_W-1:0];
				got.index_error = m_tuser;
				if (pending_forms.size() == 0) begin
					note_mismatch("result beat with no query pending", '0, 64'(got));
				end else begin
					want = pending_forms.pop_front();
					if (got.form_value !== want.form_value)
						note_mismatch("form_value", 64'(want.form_value), 64'(got.form_value));
					if (got.index_error !== want.index_error)
						note_mismatch("index_error", 64'(want.index_error), 64'(got.index_error));
				end
			end

			// Loads update the mirror; queries queue their expected result.
			if (s_tvalid && s_tready) begin
				op = op_t'(s_tuser);
				first_idx = s_tdata[INDEX_W-1:0];
				second_idx = s_tdata[2*INDEX_W-1:INDEX_W];
				case (op)
					OP_LOAD_GRAM: begin
						if (first_idx < MAX_DIMENSION && second_idx < MAX_DIMENSION)
							gram_mem[first_idx][second_idx] =
								s_tdata[2*INDEX_W+GRAM_W-1:2*INDEX_W];
					end
					OP_LOAD_VECTOR: begin
						if (first_idx < MAX_VECTORS && second_idx < MAX_DIMENSION)
							vec_mem[first_idx][second_idx] =
								s_tdata[IN_DATA_W-1:IN_DATA_W-COMP_W];
					end
					OP_QUERY: begin
						pending_forms = {pending_forms, predict_form(first_idx, second_idx)};
					end
					default: begin
					end
				endcase
			end

			outstanding <= pending_forms.size();
			fail_count <= mismatches;
		end
	end

endmodule

/* test/tb_gram_bilinear_form_matrix_core.sv */
// Testbench top for the bilinear form core: stimulus, register phases, watchdog and verdict.
`timescale 1ns / 1ps

module tb_gram_bilinear_form_matrix_core;
	import gbf_pkg::*;

	localparam int MAXD          = MAX_DIMENSION_DEF;
	localparam int MAXV          = MAX_VECTORS_DEF;
	localparam int NUM_PHASES    = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata;
	logic [OP_W-1:0]         s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    m_tuser;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	int                      outstanding;
	int                      fail_count;

	// Flow control knobs, partly shared with the receiver process, and the watchdog's idle count.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int quiet_cycles   = 0;

	// Active settings as the stimulus sees them, and which store entries hold data.
	int n_eff;
	int cnt_eff;
	bit extreme_mode;
	bit gram_written [MAXD][MAXD];
	bit vec_written [MAXV][MAXD];

	gram_bilinear_form_matrix_core #(
		.MAX_DIMENSION(MAXD),
		.MAX_VECTORS(MAXV)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	gbf_form_checker #(
		.MAX_DIMENSION(MAXD),
		.MAX_VECTORS(MAXV)
	) form_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles with no beat on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic bit gram_ready();
		for (int i = 0; i < n_eff; i++)
			for (int j = 0; j < n_eff; j++)
				if (!gram_written[i][j])
					return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit vec_ready(int v);
		for (int k = 0; k < n_eff; k++)
			if (!vec_written[v][k])
				return 1'b0;
		return 1'b1;
	endfunction

	// Mostly a small working set of vectors, so that queries find loaded pairs.
	function automatic int pick_vec();
		if (cnt_eff == 0)
			return $urandom_range(0, 255);
		if ($urandom_range(0, 3) != 0)
			return $urandom_range(0, (cnt_eff < 12 ? cnt_eff : 12) - 1);
		return $urandom_range(0, cnt_eff - 1);
	endfunction

	function automatic logic [GRAM_W-1:0] gram_value();
		if (extreme_mode && $urandom_range(0, 99) < 85)
			return 32'h8000_0000;
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0001_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [COMP_W-1:0] comp_value();
		if (extreme_mode && $urandom_range(0, 99) < 85)
			return 8'h80;
		case ($urandom_range(0, 7))
			0: return 8'h80;
			1: return 8'h7f;
			2: return 8'h00;
			3: return 8'hff;
			default: return COMP_W'($urandom);
		endcase
	endfunction

	// Offer one input beat after a random gap; returns at the edge that takes it.
	task automatic send_beat(logic [OP_W-1:0] op, logic [INDEX_W-1:0] fi,
			logic [INDEX_W-1:0] si, logic [GRAM_W-1:0] gw, logic [COMP_W-1:0] cv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		if (op == OP_LOAD_GRAM && fi < MAXD && si < MAXD)
			gram_written[fi][si] = 1'b1;
		if (op == OP_LOAD_VECTOR && fi < MAXV && si < MAXD)
			vec_written[fi][si] = 1'b1;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {cv, gw, si, fi};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Writes both registers, then one unknown index; upper data bits carry noise.
	task automatic set_config(int dim_val, int cnt_val);
		logic [CFG_INDEX_W-1:0] idx [3];
		logic [CFG_DATA_W-1:0]  val [3];
		idx[0] = REG_DIMENSION;
		val[0] = CFG_DATA_W'($urandom);
		val[0][4:0] = 5'(dim_val);
		idx[1] = REG_VECTOR_COUNT;
		val[1] = CFG_DATA_W'($urandom);
		val[1][8:0] = 9'(cnt_val);
		idx[2] = CFG_INDEX_W'($urandom_range(2, 255));
		val[2] = CFG_DATA_W'($urandom);
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		n_eff = (dim_val & 31) > MAXD ? MAXD : (dim_val & 31);
		cnt_eff = (cnt_val & 511) > MAXV ? MAXV : (cnt_val & 511);
	endtask

	// Drain: every query answered, then a settling wait for a trailing load.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random beat. Queries other than index-error queries only name fully loaded vectors
	// over a fully loaded Gram block; when that is not yet true, the beat fills a missing entry instead.
	task automatic random_beat(output bit counted);
		logic [OP_W-1:0]    op;
		logic [INDEX_W-1:0] fi;
		logic [INDEX_W-1:0] si;
		logic [GRAM_W-1:0]  gw;
		logic [COMP_W-1:0]  cv;
		int                 kind;
		int                 r2;
		int                 v;
		int                 a_vec;
		int                 b_vec;
		bit                 fill;
		bit                 found;
		fi = INDEX_W'($urandom);
		si = INDEX_W'($urandom);
		gw = $urandom;
		cv = COMP_W'($urandom);
		counted = 1'b1;
		fill = 1'b0;
		v = pick_vec();
		kind = $urandom_range(0, 99);

		if (kind < 40) begin
			if (cnt_eff == 0 || (cnt_eff < MAXV && $urandom_range(0, 6) == 0)) begin
				// At least one index at or above the vector count.
				op = OP_QUERY;
				fi = INDEX_W'($urandom_range(cnt_eff, 255));
				if ($urandom_range(0, 1)) begin
					si = fi;
					fi = INDEX_W'($urandom);
				end
			end else begin
				found = 1'b0;
				a_vec = 0;
				repeat (8) begin
					v = pick_vec();
					if (!found && vec_ready(v)) begin
						a_vec = v;
						found = 1'b1;
					end
				end
				b_vec = pick_vec();
				if (!vec_ready(b_vec))
					b_vec = a_vec;
				if (!gram_ready()) begin
					kind = 40;
					fill = 1'b1;
				end else if (!found) begin
					kind = 70;
					fill = 1'b1;
				end else begin
					op = OP_QUERY;
					fi = INDEX_W'(a_vec);
					si = INDEX_W'(b_vec);
				end
			end
		end

		// Gram entry loads, a few out of range.
		if (kind >= 40 && kind < 65) begin
			op = OP_LOAD_GRAM;
			fi = INDEX_W'($urandom_range(0, MAXD - 1));
			si = INDEX_W'($urandom_range(0, MAXD - 1));
			r2 = $urandom_range(0, 99);
			if (!fill && r2 < 10) begin
				if ($urandom_range(0, 1))
					fi = INDEX_W'($urandom_range(MAXD, 255));
				else
					si = INDEX_W'($urandom_range(MAXD, 255));
				counted = 1'b0;
			end else if (fill || r2 < 60) begin
				found = 1'b0;
				for (int i = 0; i < n_eff; i++)
					for (int j = 0; j < n_eff; j++)
						if (!found && !gram_written[i][j]) begin
							fi = INDEX_W'(i);
							si = INDEX_W'(j);
							found = 1'b1;
						end
			end
			gw = gram_value();
		end else if (kind >= 65 && kind < 95) begin
			// Vector component loads, a few with the component out of range.
			op = OP_LOAD_VECTOR;
			if (!fill)
				v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : pick_vec();
			fi = INDEX_W'(v);
			si = INDEX_W'($urandom_range(0, MAXD - 1));
			r2 = $urandom_range(0, 99);
			if (!fill && r2 < 10) begin
				si = INDEX_W'($urandom_range(MAXD, 255));
				counted = 1'b0;
			end else if (fill || r2 < 60) begin
				found = 1'b0;
				for (int k = 0; k < n_eff; k++)
					if (!found && !vec_written[v][k]) begin
						si = INDEX_W'(k);
						found = 1'b1;
					end
			end
			cv = comp_value();
		end else if (kind >= 95) begin
			op = OP_UNUSED;
			counted = 1'b0;
		end

		send_beat(op, fi, si, gw, cv);
	endtask

	initial begin
		int dim_val;
		int cnt_val;
		int items;
		int done_items;
		bit counted;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		extreme_mode = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a 2x2 Gram block with the word extremes and vectors with the component extremes.
		set_config(2, 4);
		send_beat(OP_LOAD_GRAM, 0, 0, 32'h8000_0000, COMP_W'($urandom));
		send_beat(OP_LOAD_GRAM, 0, 1, 32'h7fff_ffff, COMP_W'($urandom));
		send_beat(OP_LOAD_GRAM, 1, 0, 32'h0001_0000, COMP_W'($urandom));
		send_beat(OP_LOAD_GRAM, 1, 1, 32'hffff_ffff, COMP_W'($urandom));
		// Loads outside the stores are dropped.
		send_beat(OP_LOAD_GRAM, 16, 0, $urandom, COMP_W'($urandom));
		send_beat(OP_LOAD_GRAM, 3, 255, $urandom, COMP_W'($urandom));
		send_beat(OP_LOAD_VECTOR, 0, 0, $urandom, 8'h80);
		send_beat(OP_LOAD_VECTOR, 0, 1, $urandom, 8'h7f);
		send_beat(OP_LOAD_VECTOR, 1, 0, $urandom, 8'h80);
		send_beat(OP_LOAD_VECTOR, 1, 1, $urandom, 8'h80);
		send_beat(OP_LOAD_VECTOR, 3, 0, $urandom, 8'h01);
		send_beat(OP_LOAD_VECTOR, 3, 1, $urandom, 8'h00);
		send_beat(OP_LOAD_VECTOR, 2, 16, $urandom, COMP_W'($urandom));
		send_beat(OP_LOAD_VECTOR, 255, 255, $urandom, COMP_W'($urandom));
		send_beat(OP_UNUSED, INDEX_W'($urandom), INDEX_W'($urandom), $urandom,
			COMP_W'($urandom));
		send_beat(OP_QUERY, 0, 0, $urandom, COMP_W'($urandom));
		send_beat(OP_QUERY, 0, 1, $urandom, COMP_W'($urandom));
		send_beat(OP_QUERY, 1, 1, $urandom, COMP_W'($urandom));
		send_beat(OP_QUERY, 1, 3, $urandom, COMP_W'($urandom));
		send_beat(OP_QUERY, 3, 0, $urandom, COMP_W'($urandom));
		// Index errors: just past the count, and the largest index on either side.
		send_beat(OP_QUERY, 4, 0, $urandom, COMP_W'($urandom));
		send_beat(OP_QUERY, 0, 255, $urandom, COMP_W'($urandom));
		send_beat(OP_QUERY, 255, 255, $urandom, COMP_W'($urandom));

		// Random phases over register settings, flow-control modes and one hold-off.
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin dim_val = 1;  cnt_val = 4;   items = 150; end
				1: begin dim_val = 2;  cnt_val = 8;   items = 200; end
				2: begin dim_val = 3;  cnt_val = 256; items = 150; end
				3: begin dim_val = 0;  cnt_val = 16;  items = 60;  end
				4: begin dim_val = 4;  cnt_val = 0;   items = 60;  end
				5: begin dim_val = 16; cnt_val = 3;   items = 500; end
				6: begin dim_val = 31; cnt_val = 511; items = 150; end
				7: begin dim_val = 5;  cnt_val = 200; items = 250; end
				8: begin dim_val = 8;  cnt_val = 64;  items = 200; end
				default: begin dim_val = 2; cnt_val = 1; items = 100; end
			endcase
			set_config(dim_val, cnt_val);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			extreme_mode = (p == 5);
			if (p == 7)
				hold_requests++;
			done_items = 0;
			while (done_items < items) begin
				random_beat(counted);
				if (counted)
					done_items++;
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/gbf_pkg.sv
hw/rtl/gbf_ctrl.sv
hw/rtl/gbf_datapath.sv
hw/rtl/gram_bilinear_form_matrix_core.sv
test/gbf_form_checker.sv
test/tb_gram_bilinear_form_matrix_core.sv
